### rtl/aavr_pkg.sv
`default_nettype none
package aavr_pkg;

	// CORDIC iteration count, capped at the arctangent table length
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_COUNT    = 24;
	localparam int CORDIC_N      = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;

	// CORDIC datapath width, angles at scale 2^30
	localparam int CW = 34;
	localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1686629713;
	localparam logic signed [CW-1:0] ANG_PI      = 34'sd3373259426;
	localparam logic signed [CW-1:0] KGAIN       = 34'sd652032874;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] angle;
	} in_t;

	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
		logic               clipped;
	} out_t;

	// CORDIC result handed to the vector math
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 neg;
		in_t                  pl;
	} cor_t;

	// arctangent of 2^-i at scale 2^30
	function automatic logic signed [CW-1:0] atan_lut(input int i);
		logic signed [CW-1:0] r;
		case (i)
			0:  r = 34'sh03243F6A8;
			1:  r = 34'sh01DAC6705;
			2:  r = 34'sh00FADBAFC;
			3:  r = 34'sh007F56EA6;
			4:  r = 34'sh003FEAB76;
			5:  r = 34'sh001FFD55B;
			6:  r = 34'sh000FFFAAA;
			7:  r = 34'sh0007FFF55;
			8:  r = 34'sh0003FFFEA;
			9:  r = 34'sh0001FFFFD;
			10: r = 34'sh0000FFFFF;
			11: r = 34'sh00007FFFF;
			12: r = 34'sh00003FFFF;
			13: r = 34'sh00001FFFF;
			14: r = 34'sh00000FFFF;
			15: r = 34'sh000007FFF;
			16: r = 34'sh000003FFF;
			17: r = 34'sh000001FFF;
			18: r = 34'sh000000FFF;
			19: r = 34'sh0000007FF;
			20: r = 34'sh0000003FF;
			21: r = 34'sh0000001FF;
			22: r = 34'sh0000000FF;
			23: r = 34'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/aavr_cordic.sv
`default_nettype none
module aavr_cordic (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire aavr_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output aavr_pkg::cor_t     out_data
);
	import aavr_pkg::*;

	logic signed [CW-1:0] x_sn [0:CORDIC_N];
	logic signed [CW-1:0] y_sn [0:CORDIC_N];
	logic signed [CW-1:0] z_sn [0:CORDIC_N];
	logic                 neg_sn [0:CORDIC_N];
	in_t                  pl_sn [0:CORDIC_N];
	logic                 vld_sn [0:CORDIC_N];
	logic                 rdy [0:CORDIC_N+1];

	logic signed [CW-1:0] z0;
	logic signed [CW-1:0] zf;
	logic                 negf;

	assign rdy[CORDIC_N+1] = out_ready;
	assign in_ready        = rdy[0];

	// quadrant fold into +-pi/2
	always_comb begin
		z0   = CW'(in_data.angle) <<< 17;
		zf   = z0;
		negf = 1'b0;
		if (z0 > ANG_HALF_PI) begin
			zf   = z0 - ANG_PI;
			negf = 1'b1;
		end else if (z0 < -ANG_HALF_PI) begin
			zf   = z0 + ANG_PI;
			negf = 1'b1;
		end
	end

	assign rdy[0] = !vld_sn[0] || rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_sn[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x_sn[0]   <= KGAIN;
			y_sn[0]   <= '0;
			z_sn[0]   <= zf;
			neg_sn[0] <= negf;
			pl_sn[0]  <= in_data;
		end
	end

	// one micro-rotation per stage
	for (genvar k = 1; k <= CORDIC_N; k++) begin : g_stage
		assign rdy[k] = !vld_sn[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_sn[k] <= vld_sn[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				if (!z_sn[k-1][CW-1]) begin
					x_sn[k] <= x_sn[k-1] - (y_sn[k-1] >>> (k-1));
					y_sn[k] <= y_sn[k-1] + (x_sn[k-1] >>> (k-1));
					z_sn[k] <= z_sn[k-1] - atan_lut(k-1);
				end else begin
					x_sn[k] <= x_sn[k-1] + (y_sn[k-1] >>> (k-1));
					y_sn[k] <= y_sn[k-1] - (x_sn[k-1] >>> (k-1));
					z_sn[k] <= z_sn[k-1] + atan_lut(k-1);
				end
				neg_sn[k] <= neg_sn[k-1];
				pl_sn[k]  <= pl_sn[k-1];
			end
		end
	end

	assign out_valid    = vld_sn[CORDIC_N];
	assign out_data.x   = x_sn[CORDIC_N];
	assign out_data.y   = y_sn[CORDIC_N];
	assign out_data.neg = neg_sn[CORDIC_N];
	assign out_data.pl  = pl_sn[CORDIC_N];

endmodule
`default_nettype wire

### rtl/aavr_math.sv
`default_nettype none
module aavr_math (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire aavr_pkg::cor_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output aavr_pkg::out_t      out_data
);
	import aavr_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6     = !vld_s6 || out_ready;
	assign rdy5     = !vld_s5 || rdy6;
	assign rdy4     = !vld_s4 || rdy5;
	assign rdy3     = !vld_s3 || rdy4;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
			if (rdy6) vld_s6 <= vld_s5;
		end
	end

	// stage 1: sine/cosine rounding, axis-vector products
	logic signed [CW-1:0] xn, yn;
	logic signed [CW:0]   xr, yr;
	logic signed [17:0]   c0, s0;
	logic signed [31:0]   v0 [3];
	logic signed [15:0]   a0 [3];

	always_comb begin
		xn    = in_data.neg ? -in_data.x : in_data.x;
		yn    = in_data.neg ? -in_data.y : in_data.y;
		xr    = (CW+1)'(xn) + 35'sd32768;
		yr    = (CW+1)'(yn) + 35'sd32768;
		c0    = 18'(xr >>> 16);
		s0    = 18'(yr >>> 16);
		v0[0] = in_data.pl.vec_x;
		v0[1] = in_data.pl.vec_y;
		v0[2] = in_data.pl.vec_z;
		a0[0] = in_data.pl.axis_x;
		a0[1] = in_data.pl.axis_y;
		a0[2] = in_data.pl.axis_z;
	end

	logic signed [17:0] c_s1, s_s1;
	logic signed [18:0] omc_s1;
	logic signed [47:0] pp_s1 [3][3];
	logic signed [31:0] v_s1 [3];
	logic signed [15:0] a_s1 [3];

	always_ff @(posedge clk) begin
		if (rdy1) begin
			c_s1   <= c0;
			s_s1   <= s0;
			omc_s1 <= 19'sd16384 - 19'(c0);
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= v0[i];
				a_s1[i] <= a0[i];
				for (int j = 0; j < 3; j++) begin
					pp_s1[i][j] <= 48'(a0[i]) * 48'(v0[j]);
				end
			end
		end
	end

	// stage 2: cross and dot sums, v*cos
	logic signed [48:0] cr_s2 [3];
	logic signed [49:0] dot_s2;
	logic signed [49:0] pv_s2 [3];
	logic signed [17:0] s_s2;
	logic signed [18:0] omc_s2;
	logic signed [15:0] a_s2 [3];

	always_ff @(posedge clk) begin
		if (rdy2) begin
			cr_s2[0] <= 49'(pp_s1[1][2]) - 49'(pp_s1[2][1]);
			cr_s2[1] <= 49'(pp_s1[2][0]) - 49'(pp_s1[0][2]);
			cr_s2[2] <= 49'(pp_s1[0][1]) - 49'(pp_s1[1][0]);
			dot_s2   <= 50'(pp_s1[0][0]) + 50'(pp_s1[1][1]) + 50'(pp_s1[2][2]);
			for (int i = 0; i < 3; i++) begin
				pv_s2[i] <= 50'(v_s1[i]) * 50'(c_s1);
				a_s2[i]  <= a_s1[i];
			end
			s_s2   <= s_s1;
			omc_s2 <= omc_s1;
		end
	end

	// stage 3: cross*sin, dot*(1-cos), round v*cos
	logic signed [67:0] cs_s3 [3];
	logic signed [69:0] dp_s3;
	logic signed [35:0] t1_s3 [3];
	logic signed [15:0] a_s3 [3];
	logic signed [50:0] pvr [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pvr[i] = 51'(pv_s2[i]) + 51'sd8192;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int i = 0; i < 3; i++) begin
				cs_s3[i] <= 68'(cr_s2[i]) * 68'(s_s2);
				t1_s3[i] <= 36'(pvr[i] >>> 14);
				a_s3[i]  <= a_s2[i];
			end
			dp_s3 <= 70'(dot_s2) * 70'(omc_s2);
		end
	end

	// stage 4: round the scale 2^44 products to scale 2^16
	logic signed [68:0] csr [3];
	logic signed [70:0] dpr;
	logic signed [39:0] t2_s4 [3];
	logic signed [41:0] p_s4;
	logic signed [35:0] t1_s4 [3];
	logic signed [15:0] a_s4 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			csr[i] = 69'(cs_s3[i]) + 69'sd134217728;
		end
		dpr = 71'(dp_s3) + 71'sd134217728;
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			for (int i = 0; i < 3; i++) begin
				t2_s4[i] <= 40'(csr[i] >>> 28);
				t1_s4[i] <= t1_s3[i];
				a_s4[i]  <= a_s3[i];
			end
			p_s4 <= 42'(dpr >>> 28);
		end
	end

	// stage 5: axis times projection
	logic signed [57:0] ap_s5 [3];
	logic signed [39:0] t2_s5 [3];
	logic signed [35:0] t1_s5 [3];

	always_ff @(posedge clk) begin
		if (rdy5) begin
			for (int i = 0; i < 3; i++) begin
				ap_s5[i] <= 58'(a_s4[i]) * 58'(p_s4);
				t2_s5[i] <= t2_s4[i];
				t1_s5[i] <= t1_s4[i];
			end
		end
	end

	// stage 6: sum the three terms and saturate
	logic signed [58:0] apr [3];
	logic signed [47:0] sum [3];
	logic signed [31:0] sat [3];
	logic [2:0]         clp;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			apr[i] = 59'(ap_s5[i]) + 59'sd8192;
			sum[i] = 48'(t1_s5[i]) + 48'(t2_s5[i]) + 48'(apr[i] >>> 14);
			if (sum[i] > 48'sd2147483647) begin
				sat[i] = 32'sh7FFFFFFF;
				clp[i] = 1'b1;
			end else if (sum[i] < -48'sd2147483648) begin
				sat[i] = 32'sh80000000;
				clp[i] = 1'b1;
			end else begin
				sat[i] = 32'(sum[i]);
				clp[i] = 1'b0;
			end
		end
	end

	out_t res_s6;

	always_ff @(posedge clk) begin
		if (rdy6) begin
			res_s6.rot_x   <= sat[0];
			res_s6.rot_y   <= sat[1];
			res_s6.rot_z   <= sat[2];
			res_s6.clipped <= |clp;
		end
	end

	assign out_valid = vld_s6;
	assign out_data  = res_s6;

endmodule
`default_nettype wire

### rtl/axis_angle_vector_rotate_top.sv
`default_nettype none
// Rodrigues rotation of a Q16.16 vector about a Q1.14 axis (used as given,
// not normalized) by a Q2.13 angle. Fully pipelined: one beat in and one beat
// out per cycle unless out_ready stalls the output; a beat passes the fold
// register, one register per CORDIC iteration and six math stages. Each
// stage holds its beat only while the stage after it is full and stalled, so
// bubbles collapse and in_ready stays high while any stage is empty. Results
// saturate to 32 bits and clipped flags any saturated component.
module axis_angle_vector_rotate_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire aavr_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output aavr_pkg::out_t     out_data
);
	import aavr_pkg::*;

	logic cor_valid, cor_ready;
	cor_t cor_data;

	aavr_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (cor_valid),
		.out_ready (cor_ready),
		.out_data  (cor_data)
	);

	aavr_math u_math (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cor_valid),
		.in_ready  (cor_ready),
		.in_data   (cor_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// a full pipeline can only come from a stalled output
	a_stall_src : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while output drains");

	// clipped beat carries at least one rail value
	a_clip_rail : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.clipped) |->
		(out_data.rot_x == 32'sh7FFFFFFF || out_data.rot_x == 32'sh80000000 ||
		 out_data.rot_y == 32'sh7FFFFFFF || out_data.rot_y == 32'sh80000000 ||
		 out_data.rot_z == 32'sh7FFFFFFF || out_data.rot_z == 32'sh80000000))
		else $error("clipped set without a saturated component");

endmodule
`default_nettype wire
